FILE: design/sier_pkg.sv
// Package for the serial input expander reader.
// Holds the sequencer phase type, operation and status codes, register indexes and widths.
// No dependencies.
package sier_pkg;

  localparam int MAX_CHIPS   = 8;
  localparam int CHIP_W      = 4;
  localparam int TICK_W      = 8;
  localparam int BITNUM_W    = 8;
  localparam int REQ_W       = 4;
  localparam int WORD_W      = 64;
  localparam int BIT_CNT_W   = $clog2(WORD_W);
  localparam int TOTAL_W     = BIT_CNT_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int BITS_PER_CHIP = 8;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LOAD_HIGH = 3'd1,
    PH_LOAD_LOW  = 3'd2,
    PH_CLK_LOW   = 3'd3,
    PH_CLK_HIGH  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_READ_ALL = 2'd1,
    OP_READ_BIT = 2'd2,
    OP_SPARE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LEN_MISMATCH = 2'd1,
    ST_BIT_RANGE    = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS      = 1'd1;

  // Sample k lands in word bit k XOR 7: first sample of a chip in its high bit.
  localparam logic [BIT_CNT_W-1:0] BIT_SWAP = BIT_CNT_W'(BITS_PER_CHIP - 1);

endpackage

FILE: design/serial_input_expander_reader_unit.sv
// Top level of the serial input expander reader: pin sequencer for a cascade of
// parallel-in serial-out shift register chips, with its result register.
// Depends on sier_pkg.
//
// Usage: every input beat is one timing tick of the sequencer and produces exactly
// one result beat carrying the load and clock pin levels, busy and done flags, the
// collected data word, the sampled bit and a status code.
// A read-all (operation 1) or single-bit read (operation 2) starts from idle; it
// pulses load high then low and then, for each bit, samples serial_in and drives
// the clock low then high, each level held for ticks_per_phase ticks.
// The result beat of each accepted input beat is registered and appears in the cycle after it.
// Throughput: one beat per cycle unless stalled; the whole tick update is a single
// pass of logic between the sequencer state registers and the result register.
// Configuration: cfg_index 0 is chip_count, 1 is ticks_per_phase; the port is
// always ready and is meant to be written while no read is running.
// Reset: synchronous, active high; clears the sequencer to idle, both pin levels
// low, chip_count and ticks_per_phase to one, and empties the result register.
// Stall: while a result beat waits under result_stall, item_stall is raised and
// no new tick is taken; the pending result holds steady.
module serial_input_expander_reader_unit
  import sier_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            operation,
  input  logic [REQ_W-1:0]      requested_length,
  input  logic [BITNUM_W-1:0]   bit_number,
  input  logic                  serial_in,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  load_pin,
  output logic                  clock_pin,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [WORD_W-1:0]     data_word,
  output logic                  sampled_bit,
  output logic [1:0]            status
);

  logic [CHIP_W-1:0]    chip_count;
  logic [TICK_W-1:0]    ticks_per_phase;

  phase_t               phase, phase_next;
  logic [TICK_W-1:0]    phase_timer, phase_timer_next;
  logic [BIT_CNT_W-1:0] bits_done, bits_done_next;
  logic [WORD_W-1:0]    received_word, received_word_next;
  logic                 read_mode, read_mode_next;
  logic [BIT_CNT_W-1:0] target_position, target_position_next;
  logic                 load_level, load_level_next;
  logic                 clock_level, clock_level_next;

  logic                 item_take;
  logic [CHIP_W-1:0]    eff_chips;
  logic [TOTAL_W-1:0]   total_bits;
  logic [TICK_W-1:0]    hold_ticks;
  logic                 done_next;
  status_t              status_next;
  logic [WORD_W-1:0]    word_next;
  logic                 bstate_next;
  op_t                  op;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid & result_stall;
  assign item_take  = item_valid & ~item_stall;
  assign op         = op_t'(operation);

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_count      <= CHIP_W'(1);
      ticks_per_phase <= TICK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CHIP_COUNT) begin
        chip_count <= cfg_data[CHIP_W-1:0];
      end else if (cfg_index == CFG_TICKS) begin
        ticks_per_phase <= cfg_data[TICK_W-1:0];
      end
    end
  end

  // Zero chips counts as one, anything beyond the cascade limit as the limit.
  always_comb begin
    if (chip_count == '0) begin
      eff_chips = CHIP_W'(1);
    end else if (chip_count > CHIP_W'(MAX_CHIPS)) begin
      eff_chips = CHIP_W'(MAX_CHIPS);
    end else begin
      eff_chips = chip_count;
    end
  end

  assign total_bits = TOTAL_W'({eff_chips, 3'b000});
  assign hold_ticks = (ticks_per_phase == '0) ? '0 : ticks_per_phase - TICK_W'(1);

  always_comb begin
    logic                 sample;
    logic                 finish;
    logic [BIT_CNT_W-1:0] sample_idx;
    logic [BIT_CNT_W-1:0] bits_inc;

    phase_next           = phase;
    phase_timer_next     = phase_timer;
    bits_done_next       = bits_done;
    received_word_next   = received_word;
    read_mode_next       = read_mode;
    target_position_next = target_position;
    load_level_next      = load_level;
    clock_level_next     = clock_level;
    done_next            = 1'b0;
    status_next          = ST_OK;
    word_next            = '0;
    bstate_next          = 1'b0;
    sample               = 1'b0;
    finish               = 1'b0;
    bits_inc             = bits_done + BIT_CNT_W'(1);
    sample_idx           = bits_done;

    if (phase == PH_IDLE) begin
      if (op == OP_READ_ALL && requested_length != eff_chips) begin
        done_next   = 1'b1;
        status_next = ST_LEN_MISMATCH;
      end else if (op == OP_READ_BIT && bit_number >= BITNUM_W'(total_bits)) begin
        done_next   = 1'b1;
        status_next = ST_BIT_RANGE;
      end else if (op == OP_READ_ALL || op == OP_READ_BIT) begin
        read_mode_next       = (op == OP_READ_BIT);
        target_position_next = bit_number[BIT_CNT_W-1:0] ^ BIT_SWAP;
        received_word_next   = '0;
        bits_done_next       = '0;
        load_level_next      = 1'b1;
        phase_next           = PH_LOAD_HIGH;
        phase_timer_next     = hold_ticks;
      end
    end else if (phase_timer != '0) begin
      phase_timer_next = phase_timer - TICK_W'(1);
    end else begin
      unique case (phase)
        PH_LOAD_HIGH: begin
          load_level_next  = 1'b0;
          phase_next       = PH_LOAD_LOW;
          phase_timer_next = hold_ticks;
        end
        PH_LOAD_LOW: begin
          sample = 1'b1;
        end
        PH_CLK_LOW: begin
          clock_level_next = 1'b1;
          phase_next       = PH_CLK_HIGH;
          phase_timer_next = hold_ticks;
        end
        default: begin
          if (!read_mode && ({1'b0, bits_done} + TOTAL_W'(1)) >= total_bits) begin
            finish    = 1'b1;
            word_next = received_word;
          end else begin
            bits_done_next = bits_inc;
            sample_idx     = bits_inc;
            sample         = 1'b1;
          end
        end
      endcase

      if (sample) begin
        if (read_mode && sample_idx == target_position) begin
          finish      = 1'b1;
          bstate_next = serial_in;
        end else begin
          if (!read_mode) begin
            received_word_next = received_word |
                                 (WORD_W'(serial_in) << (sample_idx ^ BIT_SWAP));
          end
          clock_level_next = 1'b0;
          phase_next       = PH_CLK_LOW;
          phase_timer_next = hold_ticks;
        end
      end

      if (finish) begin
        done_next        = 1'b1;
        phase_next       = PH_IDLE;
        phase_timer_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_timer     <= '0;
      bits_done       <= '0;
      received_word   <= '0;
      read_mode       <= 1'b0;
      target_position <= '0;
      load_level      <= 1'b0;
      clock_level     <= 1'b0;
    end else if (item_take) begin
      phase           <= phase_next;
      phase_timer     <= phase_timer_next;
      bits_done       <= bits_done_next;
      received_word   <= received_word_next;
      read_mode       <= read_mode_next;
      target_position <= target_position_next;
      load_level      <= load_level_next;
      clock_level     <= clock_level_next;
    end
  end

  // Result register: a waiting beat holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      load_pin    <= load_level_next;
      clock_pin   <= clock_level_next;
      busy_res    <= (phase_next != PH_IDLE);
      done_res    <= done_next;
      data_word   <= word_next;
      sampled_bit <= bstate_next;
      status      <= status_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(done_res && busy_res))
    else $error("result beat is both done and busy");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> done_res)
    else $error("error status outside a done beat");

  a_payload_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (data_word != '0 || sampled_bit)) |-> done_res)
    else $error("data or sampled bit outside a done beat");

  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    item_take |=> (busy_res == (phase != PH_IDLE)))
    else $error("busy flag disagrees with sequencer phase");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !item_valid) |=> !result_valid)
    else $error("result beat repeated after it was taken");

endmodule
